// File: rtl/zvs_pkg.sv
package zvs_pkg;

    localparam int APB_AW = 4;

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_EVAL   = 1'b1;

    localparam logic [4:0]  ZONES_IN_USE_RST = 5'd6;
    localparam logic [18:0] CHUNKS_RST       = 19'd1;
    localparam logic [4:0]  THRESHOLD_RST    = 5'd1;

    localparam logic [63:0] SUM_ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef enum logic [1:0] {
        CFG_ZONES_IN_USE = 2'd0,
        CFG_CHUNKS       = 2'd1,
        CFG_THRESHOLD    = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DEC,
        S_EVICT
    } t_state;

    typedef struct packed {
        logic        opcode;
        logic [3:0]  zone_id;
        logic [63:0] age_sum;
        logic        zone_full;
        logic [63:0] now_time;
    } t_req;

    typedef struct packed {
        logic       evicting;
        logic [3:0] victim_zone;
        logic       slot_valid;
        logic [4:0] free_zones;
        logic       last;
    } t_rsp;

    typedef struct packed {
        logic [4:0]  zones_in_use;
        logic [18:0] zone_chunks;
        logic [4:0]  free_zone_threshold;
    } t_cfg;

    typedef struct packed {
        logic clear;
        logic insert;
    } t_slot_ctl;

endpackage

// File: rtl/zvs_if.sv
interface zvs_req_if;
    import zvs_pkg::*;

    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface zvs_rsp_if;
    import zvs_pkg::*;

    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/zvs_cfg.sv
module zvs_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [zvs_pkg::APB_AW-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output zvs_pkg::t_cfg               o_cfg
);
    import zvs_pkg::*;

    t_cfg     r_cfg;
    t_cfg_idx idx;
    logic     wr;

    assign idx    = t_cfg_idx'(paddr[APB_AW-1:2]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.zones_in_use        <= ZONES_IN_USE_RST;
            r_cfg.zone_chunks         <= CHUNKS_RST;
            r_cfg.free_zone_threshold <= THRESHOLD_RST;
        end else if (wr) begin
            case (idx)
                CFG_ZONES_IN_USE: r_cfg.zones_in_use        <= pwdata[4:0];
                CFG_CHUNKS:       r_cfg.zone_chunks         <= pwdata[18:0];
                CFG_THRESHOLD:    r_cfg.free_zone_threshold <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            CFG_ZONES_IN_USE: prdata = 32'(r_cfg.zones_in_use);
            CFG_CHUNKS:       prdata = 32'(r_cfg.zone_chunks);
            CFG_THRESHOLD:    prdata = 32'(r_cfg.free_zone_threshold);
            default:          prdata = '0;
        endcase
    end

endmodule

// File: rtl/zvs_zone_mem.sv
module zvs_zone_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [64:0]   i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [64:0]   o_rdata
);
    logic [64:0]      r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [64:0]      r_rdata;
    logic             r_rvld;

    // full flag in the top bit, age sum below
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    // entries never written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_rvld <= r_vld[i_raddr];
            end
        end
    end

    assign o_rdata = r_rvld ? r_rdata : '0;

endmodule

// File: rtl/zvs_mul.sv
module zvs_mul (
    input  logic        i_clk,
    input  logic [63:0] i_a,
    input  logic [18:0] i_b,
    output logic [63:0] o_prod
);
    logic [50:0] r_plo;
    logic [31:0] r_phi;
    logic [63:0] r_prod;

    // product modulo 2^64 from two 32 x 19 partials
    always_ff @(posedge i_clk) begin
        r_plo  <= 51'(i_a[31:0]) * 51'(i_b);
        r_phi  <= i_a[63:32] * 32'(i_b);
        r_prod <= 64'(r_plo) + {r_phi, 32'd0};
    end

    assign o_prod = r_prod;

endmodule

// File: rtl/zvs_slot_bank.sv
module zvs_slot_bank #(
    parameter int SLOTS = 8,
    parameter int ZW    = 4,
    parameter int SW    = 3
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  zvs_pkg::t_slot_ctl   i_ctl,
    input  logic [63:0]          i_sum,
    input  logic [ZW-1:0]        i_zone,
    input  logic [SW-1:0]        i_rd_idx,
    output logic                 o_rd_filled,
    output logic [ZW-1:0]        o_rd_zone
);
    import zvs_pkg::*;

    logic [63:0]      r_val  [SLOTS];
    logic [ZW-1:0]    r_zone [SLOTS];
    logic [SLOTS-1:0] r_gt   [SLOTS];
    logic [SLOTS-1:0] r_fill;

    logic [SLOTS-1:0] lt;
    logic [SLOTS-1:0] gtv;
    logic [SLOTS-1:0] is_max;
    logic [SW-1:0]    big;
    logic             take;

    // r_gt[t][s] holds slot t value above slot s value
    always_comb begin
        for (int t = 0; t < SLOTS; t++) begin
            lt[t]  = i_sum < r_val[t];
            gtv[t] = i_sum > r_val[t];
        end
        for (int s = 0; s < SLOTS; s++) begin
            is_max[s] = 1'b1;
            for (int t = 0; t < SLOTS; t++) begin
                if (r_gt[t][s]) begin
                    is_max[s] = 1'b0;
                end
            end
        end
        big = '0;
        for (int s = SLOTS - 1; s >= 0; s--) begin
            if (is_max[s]) begin
                big = SW'(s);
            end
        end
        take = !r_fill[big] || lt[big];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            for (int s = 0; s < SLOTS; s++) begin
                r_val[s] <= SUM_ALL_ONES;
                r_gt[s]  <= '0;
            end
        end else if (i_ctl.insert && take) begin
            r_val[big]  <= i_sum;
            r_zone[big] <= i_zone;
            for (int t = 0; t < SLOTS; t++) begin
                if (SW'(t) == big) begin
                    r_gt[t][t] <= 1'b0;
                end else begin
                    r_gt[big][t] <= gtv[t];
                    r_gt[t][big] <= lt[t];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_ctl.clear) begin
            r_fill <= '0;
        end else if (i_ctl.insert && take) begin
            r_fill[big] <= 1'b1;
        end
    end

    assign o_rd_filled = r_fill[i_rd_idx];
    assign o_rd_zone   = r_zone[i_rd_idx];

endmodule

// File: rtl/zone_victim_selector.sv
// update request: written to zone memory at its accept edge, one per idle cycle, no response
// evaluate request: one zone record per cycle, then one response, or one per slot if evicting
// the request port stays closed until an evaluate's last response enters the output register
// a stalled response port holds the slot sequence; the output register frees the input side
// synchronous active-low reset clears zone records, slots, control and restores config defaults
module zone_victim_selector #(
    parameter int MAX_ZONES   = 16,
    parameter int EVICT_SLOTS = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    zvs_req_if.sink                     i_req,
    zvs_rsp_if.source                   o_rsp,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [zvs_pkg::APB_AW-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import zvs_pkg::*;

    localparam int ZW       = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1;
    localparam int SW       = (EVICT_SLOTS > 1) ? $clog2(EVICT_SLOTS) : 1;
    localparam int SCAN_CAP = (MAX_ZONES < 31) ? MAX_ZONES : 31;

    t_cfg       cfg;
    t_state     r_state, n_state;
    logic [4:0] r_zcnt, n_zcnt;
    logic [4:0] r_scan, n_scan;
    logic [4:0] r_full, n_full;
    logic [4:0] r_free, n_free;
    logic [SW-1:0] r_sidx, n_sidx;
    logic [63:0] r_now, n_now;
    logic        r_ovld, n_ovld;
    t_rsp        r_odata, n_odata;

    logic          mem_we;
    logic [ZW-1:0] mem_waddr;
    logic [64:0]   mem_wdata;
    logic          mem_re;
    logic [ZW-1:0] mem_raddr;
    logic [64:0]   mem_rdata;

    t_slot_ctl     slot_ctl;
    logic          slot_filled;
    logic [ZW-1:0] slot_zone;
    logic [63:0]   prod;

    logic       req_acc;
    logic       out_free;
    logic       zid_ok;
    logic [4:0] scan_lim;
    logic [4:0] free_now;
    logic       slot_last;

    zvs_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    zvs_zone_mem #(
        .DEPTH (MAX_ZONES),
        .AW    (ZW)
    ) u_zone_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    zvs_slot_bank #(
        .SLOTS (EVICT_SLOTS),
        .ZW    (ZW),
        .SW    (SW)
    ) u_slot_bank (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (slot_ctl),
        .i_sum       (mem_rdata[63:0]),
        .i_zone      (ZW'(r_zcnt)),
        .i_rd_idx    (r_sidx),
        .o_rd_filled (slot_filled),
        .o_rd_zone   (slot_zone)
    );

    zvs_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (r_now),
        .i_b    (cfg.zone_chunks),
        .o_prod (prod)
    );

    assign req_acc   = i_req.valid && i_req.ready;
    assign out_free  = !r_ovld || o_rsp.ready;
    assign zid_ok    = 32'(i_req.data.zone_id) < MAX_ZONES;
    assign scan_lim  = (cfg.zones_in_use > 5'(SCAN_CAP)) ? 5'(SCAN_CAP) : cfg.zones_in_use;
    assign free_now  = r_scan - r_full;
    assign slot_last = (r_sidx == SW'(EVICT_SLOTS - 1));

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_ovld;
    assign o_rsp.data  = r_odata;

    always_comb begin
        n_state   = r_state;
        n_zcnt    = r_zcnt;
        n_scan    = r_scan;
        n_full    = r_full;
        n_free    = r_free;
        n_sidx    = r_sidx;
        n_now     = r_now;
        n_ovld    = r_ovld && !o_rsp.ready;
        n_odata   = r_odata;
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = '0;
        slot_ctl  = '0;

        case (r_state)
            S_IDLE: begin
                if (req_acc) begin
                    if (i_req.data.opcode == OP_UPDATE) begin
                        if (zid_ok) begin
                            mem_we    = 1'b1;
                            mem_waddr = ZW'(i_req.data.zone_id);
                            mem_wdata = {i_req.data.zone_full, i_req.data.age_sum};
                        end
                    end else begin
                        n_now          = i_req.data.now_time;
                        slot_ctl.clear = 1'b1;
                        n_zcnt         = '0;
                        n_full         = '0;
                        n_scan         = scan_lim;
                        if (scan_lim != 5'd0) begin
                            mem_re  = 1'b1;
                            n_state = S_SCAN;
                        end else begin
                            n_state = S_DEC;
                        end
                    end
                end
            end
            S_SCAN: begin
                slot_ctl.insert = 1'b1;
                n_full = r_full + {4'd0, mem_rdata[64]};
                if (({1'b0, r_zcnt} + 6'd1) < {1'b0, r_scan}) begin
                    mem_re    = 1'b1;
                    mem_raddr = ZW'(r_zcnt + 5'd1);
                    n_zcnt    = r_zcnt + 5'd1;
                end else begin
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_free = free_now;
                if (free_now > cfg.free_zone_threshold) begin
                    if (out_free) begin
                        n_ovld              = 1'b1;
                        n_odata.evicting    = 1'b0;
                        n_odata.victim_zone = '0;
                        n_odata.slot_valid  = 1'b0;
                        n_odata.free_zones  = free_now;
                        n_odata.last        = 1'b1;
                        n_state             = S_IDLE;
                    end
                end else begin
                    n_sidx  = '0;
                    n_state = S_EVICT;
                end
            end
            S_EVICT: begin
                if (out_free) begin
                    n_ovld              = 1'b1;
                    n_odata.evicting    = 1'b1;
                    n_odata.victim_zone = slot_filled ? 4'(slot_zone) : 4'd0;
                    n_odata.slot_valid  = slot_filled;
                    n_odata.free_zones  = r_free;
                    n_odata.last        = slot_last;
                    if (slot_filled) begin
                        mem_we    = 1'b1;
                        mem_waddr = slot_zone;
                        mem_wdata = {1'b0, prod};
                    end
                    if (slot_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_sidx = r_sidx + SW'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ovld  <= 1'b0;
            r_zcnt  <= '0;
            r_scan  <= '0;
            r_full  <= '0;
            r_sidx  <= '0;
        end else begin
            r_state <= n_state;
            r_ovld  <= n_ovld;
            r_zcnt  <= n_zcnt;
            r_scan  <= n_scan;
            r_full  <= n_full;
            r_sidx  <= n_sidx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_now   <= n_now;
        r_free  <= n_free;
        r_odata <= n_odata;
    end

endmodule

// File: rtl/zvs_checker.sv
module zvs_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_req_valid,
    input logic          i_req_ready,
    input logic          i_req_opcode,
    input logic          i_rsp_valid,
    input logic          i_rsp_ready,
    input zvs_pkg::t_rsp i_rsp_data
);
    import zvs_pkg::*;

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_data))
        else $error("response dropped or changed while stalled");

    a_update_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready && (i_req_opcode == OP_UPDATE) && !i_rsp_valid
        |=> !i_rsp_valid)
        else $error("update request produced a response");

    a_eval_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready && (i_req_opcode == OP_EVAL) |=> !i_req_ready)
        else $error("request taken straight after an evaluate");

    a_evict_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_ready && i_rsp_data.evicting && !i_rsp_data.last
        |-> !i_req_ready)
        else $error("request port open before the slot sequence ended");

endmodule

bind zone_victim_selector zvs_checker u_zvs_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_req_opcode (i_req.data.opcode),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_data   (o_rsp.data)
);
